// ===== hdl/wia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_pkg
// Opcodes, stream field layout and control types shared by the wide integer
// unit.
// ----------------------------------------------------------------------------
package wia_pkg;

    localparam int FIELD_W    = 64;
    localparam int OP_W       = 4;
    localparam int SHAMT_W    = 8;

    // slave tdata layout, lowest bit first
    localparam int OFF_OP     = 0;
    localparam int OFF_A_HI   = OFF_OP + OP_W;
    localparam int OFF_A_LO   = OFF_A_HI + FIELD_W;
    localparam int OFF_B_HI   = OFF_A_LO + FIELD_W;
    localparam int OFF_B_LO   = OFF_B_HI + FIELD_W;
    localparam int OFF_SHAMT  = OFF_B_LO + FIELD_W;
    localparam int S_TDATA_W  = ((OFF_SHAMT + SHAMT_W + 7) / 8) * 8;

    // master tdata layout, lowest bit first
    localparam int OFF_RES_HI = 0;
    localparam int OFF_RES_LO = OFF_RES_HI + FIELD_W;
    localparam int OFF_REM_HI = OFF_RES_LO + FIELD_W;
    localparam int OFF_REM_LO = OFF_REM_HI + FIELD_W;
    localparam int OFF_ORDER  = OFF_REM_LO + FIELD_W;
    localparam int OFF_DZ     = OFF_ORDER + 2;
    localparam int M_TDATA_W  = ((OFF_DZ + 1 + 7) / 8) * 8;

    localparam logic [1:0] ORD_LT = 2'b11;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_MULW = 4'd3,
        OP_AND  = 4'd4,
        OP_OR   = 4'd5,
        OP_XOR  = 4'd6,
        OP_NOT  = 4'd7,
        OP_SHL  = 4'd8,
        OP_SHR  = 4'd9,
        OP_SAR  = 4'd10,
        OP_UCMP = 4'd11,
        OP_SCMP = 4'd12,
        OP_UDIV = 4'd13,
        OP_SDIV = 4'd14,
        OP_NEG  = 4'd15
    } op_t;

    // sideband that travels with each request through the divider stages
    typedef struct packed {
        logic [1:0] ord;
        logic       div;
        logic       dz;
        logic       qneg;
        logic       rneg;
    } ctl_t;

endpackage

// ===== hdl/wide_integer_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_integer_alu
// Pipeline: capture, main logic, divider load, 2*HALF_WIDTH restoring-division
// steps (one quotient bit per stage) and the output register, in that order.
// Throughput: one request per cycle; the pipeline stalls as a whole while a
// result waits on m_tready. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module wide_integer_alu #(
    parameter int HALF_WIDTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op[3:0], a_hi[67:4], a_lo[131:68], b_hi[195:132], b_lo[259:196],
    // shift_amount[267:260], zero fill
    input  logic [wia_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_hi[63:0], result_lo[127:64], remainder_hi[191:128],
    // remainder_lo[255:192], order[257:256], divide_by_zero[258], zero fill
    output logic [wia_pkg::M_TDATA_W-1:0] m_tdata
);
    import wia_pkg::*;

    localparam int HW = HALF_WIDTH;
    localparam int W  = 2 * HALF_WIDTH;
    localparam int CW = HALF_WIDTH / 2;
    localparam int CH = HALF_WIDTH - CW;
    localparam int PW = 2 * CH;
    localparam int NP = 10;

    logic en;

    // stage 1: capture
    logic               p1_valid_reg;
    op_t                p1_op_reg;
    logic [W-1:0]       p1_a_reg, p1_b_reg;
    logic [SHAMT_W-1:0] p1_n_reg;
    op_t                s_op;
    logic [HW-1:0]      s_a_hi, s_b_hi;

    // stage 2: main logic and partial products
    logic               p2_valid_reg;
    op_t                p2_op_reg;
    logic [W-1:0]       p2_res_reg, p2_res_next;
    logic [1:0]         p2_ord_next;
    logic [W-1:0]       p2_dvd_reg, p2_dvd_next;
    logic [W-1:0]       p2_dvs_reg, p2_dvs_next;
    ctl_t               p2_ctl_reg, p2_ctl_next;
    logic [PW-1:0]      mp_reg [0:NP-1];
    logic [PW-1:0]      mp_next [0:NP-1];
    logic [CH-1:0]      al0, al1, ah0, ah1, bl0, bl1, bh0, bh1;
    logic               a_neg, b_neg, is_sdiv;

    // stage 3 and divider stages
    logic               dv_valid_reg [0:W];
    logic [W-1:0]       dv_res_reg [0:W];
    logic [W-1:0]       dv_rem_reg [0:W];
    logic [W-1:0]       dv_aq_reg [0:W];
    logic [W-1:0]       dv_dvs_reg [0:W];
    ctl_t               dv_ctl_reg [0:W];
    logic [W-1:0]       mul_low, mul_full;
    logic [HW-1:0]      mul_cross;

    // output stage
    logic               m_valid_reg;
    logic [W-1:0]       m_res_reg, m_res_next;
    logic [W-1:0]       m_rem_reg, m_rem_next;
    logic [1:0]         m_ord_reg;
    logic               m_dz_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;

    // ---------------- stage 1 ----------------
    assign s_op   = op_t'(s_tdata[OFF_OP +: OP_W]);
    assign s_a_hi = (s_op == OP_MULW) ? '0 : s_tdata[OFF_A_HI +: HW];
    assign s_b_hi = (s_op == OP_MULW) ? '0 : s_tdata[OFF_B_HI +: HW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_op_reg <= s_op;
            p1_a_reg  <= {s_a_hi, s_tdata[OFF_A_LO +: HW]};
            p1_b_reg  <= {s_b_hi, s_tdata[OFF_B_LO +: HW]};
            p1_n_reg  <= s_tdata[OFF_SHAMT +: SHAMT_W];
        end
    end

    // ---------------- stage 2 ----------------
    assign al0 = CH'(p1_a_reg[CW-1:0]);
    assign al1 = CH'(p1_a_reg[HW-1:CW]);
    assign ah0 = CH'(p1_a_reg[HW+CW-1:HW]);
    assign ah1 = CH'(p1_a_reg[W-1:HW+CW]);
    assign bl0 = CH'(p1_b_reg[CW-1:0]);
    assign bl1 = CH'(p1_b_reg[HW-1:CW]);
    assign bh0 = CH'(p1_b_reg[HW+CW-1:HW]);
    assign bh1 = CH'(p1_b_reg[W-1:HW+CW]);

    assign a_neg   = p1_a_reg[W-1];
    assign b_neg   = p1_b_reg[W-1];
    assign is_sdiv = (p1_op_reg == OP_SDIV);

    always_comb begin
        mp_next[0] = al0 * bl0;
        mp_next[1] = al0 * bl1;
        mp_next[2] = al1 * bl0;
        mp_next[3] = al1 * bl1;
        mp_next[4] = al0 * bh0;
        mp_next[5] = al0 * bh1;
        mp_next[6] = al1 * bh0;
        mp_next[7] = ah0 * bl0;
        mp_next[8] = ah0 * bl1;
        mp_next[9] = ah1 * bl0;
    end

    always_comb begin
        p2_res_next = '0;
        p2_ord_next = ORD_EQ;
        case (p1_op_reg)
            OP_ADD:  p2_res_next = p1_a_reg + p1_b_reg;
            OP_SUB:  p2_res_next = p1_a_reg - p1_b_reg;
            OP_AND:  p2_res_next = p1_a_reg & p1_b_reg;
            OP_OR:   p2_res_next = p1_a_reg | p1_b_reg;
            OP_XOR:  p2_res_next = p1_a_reg ^ p1_b_reg;
            OP_NOT:  p2_res_next = ~p1_a_reg;
            OP_SHL:  p2_res_next = p1_a_reg << p1_n_reg;
            OP_SHR:  p2_res_next = p1_a_reg >> p1_n_reg;
            OP_SAR:  p2_res_next = $signed(p1_a_reg) >>> p1_n_reg;
            OP_NEG:  p2_res_next = '0 - p1_a_reg;
            OP_UCMP: begin
                if (p1_a_reg < p1_b_reg) begin
                    p2_ord_next = ORD_LT;
                end else if (p1_a_reg > p1_b_reg) begin
                    p2_ord_next = ORD_GT;
                end
            end
            OP_SCMP: begin
                if ($signed(p1_a_reg) < $signed(p1_b_reg)) begin
                    p2_ord_next = ORD_LT;
                end else if ($signed(p1_a_reg) > $signed(p1_b_reg)) begin
                    p2_ord_next = ORD_GT;
                end
            end
            default: p2_res_next = '0;
        endcase
    end

    always_comb begin
        p2_dvd_next      = (is_sdiv && a_neg) ? ('0 - p1_a_reg) : p1_a_reg;
        p2_dvs_next      = (is_sdiv && b_neg) ? ('0 - p1_b_reg) : p1_b_reg;
        p2_ctl_next.ord  = p2_ord_next;
        p2_ctl_next.div  = (p1_op_reg == OP_UDIV) || is_sdiv;
        p2_ctl_next.dz   = (p1_b_reg == '0);
        p2_ctl_next.qneg = is_sdiv && (a_neg != b_neg);
        p2_ctl_next.rneg = is_sdiv && a_neg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_op_reg  <= p1_op_reg;
            p2_res_reg <= p2_res_next;
            p2_dvd_reg <= p2_dvd_next;
            p2_dvs_reg <= p2_dvs_next;
            p2_ctl_reg <= p2_ctl_next;
            for (int i = 0; i < NP; i++) begin
                mp_reg[i] <= mp_next[i];
            end
        end
    end

    // ---------------- stage 3: product sum, divider load ----------------
    always_comb begin
        mul_low   = W'(mp_reg[0]) + (W'(mp_reg[1]) << CW) + (W'(mp_reg[2]) << CW)
                  + (W'(mp_reg[3]) << (2 * CW));
        mul_cross = HW'(mp_reg[4]) + HW'(mp_reg[7])
                  + ((HW'(mp_reg[5]) + HW'(mp_reg[6]) + HW'(mp_reg[8])
                  + HW'(mp_reg[9])) << CW);
        mul_full  = mul_low + (W'(mul_cross) << HW);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_res_reg[0] <= (p2_op_reg == OP_MUL || p2_op_reg == OP_MULW)
                           ? mul_full : p2_res_reg;
            dv_rem_reg[0] <= '0;
            dv_aq_reg[0]  <= p2_dvd_reg;
            dv_dvs_reg[0] <= p2_dvs_reg;
            dv_ctl_reg[0] <= p2_ctl_reg;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic         ge;
        logic [W-1:0] rem_next, aq_next;

        always_comb begin
            trial    = {dv_rem_reg[k], dv_aq_reg[k][W-1]};
            diff     = trial - {1'b0, dv_dvs_reg[k]};
            ge       = !diff[W];
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            aq_next  = {dv_aq_reg[k][W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_res_reg[k+1] <= dv_res_reg[k];
                dv_rem_reg[k+1] <= rem_next;
                dv_aq_reg[k+1]  <= aq_next;
                dv_dvs_reg[k+1] <= dv_dvs_reg[k];
                dv_ctl_reg[k+1] <= dv_ctl_reg[k];
            end
        end
    end

    // ---------------- output stage: sign fix and select ----------------
    always_comb begin
        m_res_next = dv_res_reg[W];
        m_rem_next = '0;
        if (dv_ctl_reg[W].div) begin
            if (dv_ctl_reg[W].dz) begin
                m_res_next = '0;
            end else begin
                m_res_next = dv_ctl_reg[W].qneg ? ('0 - dv_aq_reg[W]) : dv_aq_reg[W];
                m_rem_next = dv_ctl_reg[W].rneg ? ('0 - dv_rem_reg[W]) : dv_rem_reg[W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_res_reg <= m_res_next;
            m_rem_reg <= m_rem_next;
            m_ord_reg <= dv_ctl_reg[W].ord;
            m_dz_reg  <= dv_ctl_reg[W].div && dv_ctl_reg[W].dz;
        end
    end

    always_comb begin
        m_tdata                        = '0;
        m_tdata[OFF_RES_HI +: HW]      = m_res_reg[W-1:HW];
        m_tdata[OFF_RES_LO +: HW]      = m_res_reg[HW-1:0];
        m_tdata[OFF_REM_HI +: HW]      = m_rem_reg[W-1:HW];
        m_tdata[OFF_REM_LO +: HW]      = m_rem_reg[HW-1:0];
        m_tdata[OFF_ORDER +: 2]        = m_ord_reg;
        m_tdata[OFF_DZ]                = m_dz_reg;
    end

endmodule
